>>> rtl/core/tmlf_pkg.sv
// Shared types and constants for the text message length finder.
package tmlf_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int NAME_LEN    = 14;
  localparam int MATCH_BITS  = $clog2(NAME_LEN + 1);
  localparam int OUT_BITS    = 16;
  localparam int STATUS_BITS = 2;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_COMPLETE   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_MATCH,
    PH_SKIP,
    PH_DIGITS,
    PH_RUN,
    PH_BODY,
    PH_NULLS,
    PH_DONE
  } phase_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] position;
    logic [1:0]             term_count;
    logic                   ws_seen;
    logic                   first_lf;
    logic                   pair_equal;
    logic [MATCH_BITS-1:0]  match_idx;
    logic                   length_seen;
    logic                   bad_length;
    logic [LENGTH_BITS-1:0] declared;
    logic [LENGTH_BITS-1:0] remaining;
    logic [LENGTH_BITS-1:0] nulls;
    logic [LENGTH_BITS-1:0] header_end;
  } state_t;

  // One framing result
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [OUT_BITS-1:0]    body_length;
    logic [OUT_BITS-1:0]    header_length;
  } res_t;

  // Lowercase letters of the length header name
  function automatic logic [7:0] name_char(input logic [MATCH_BITS-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'hff;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/tmlf_in_stage.sv
// Input register: holds one accepted byte until the parser takes it.
module tmlf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,  // [7:0] byte_in
  input  logic       in_tlast,  // end_of_buffer
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_last
);
  import tmlf_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  // Accept when empty or when the held item leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_last  = last_r;
endmodule

>>> rtl/core/tmlf_parser.sv
// Header scanner: updates the framing state on each byte and forms the result.
module tmlf_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output logic                res_valid,
  output tmlf_pkg::res_t      res
);
  import tmlf_pkg::*;

  localparam int PROD_BITS = LENGTH_BITS + 4;

  state_t state_r, state_nxt;
  state_t s, fin;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? LEN_MAX : v + 1'b1;
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic state_t start_run(input state_t st, input logic [7:0] b);
    state_t o;
    o            = st;
    o.phase      = PH_RUN;
    o.term_count = 2'd1;
    o.ws_seen    = 1'b0;
    o.first_lf   = (b == CHAR_LF);
    o.pair_equal = 1'b0;
    return o;
  endfunction

  function automatic state_t match_byte(input state_t st, input logic [7:0] b);
    state_t     o;
    logic [7:0] lower;
    o     = st;
    lower = ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) ? (b | 8'h20) : b;
    if ((st.match_idx < MATCH_BITS'(NAME_LEN)) && (lower == name_char(st.match_idx))) begin
      o.match_idx = st.match_idx + 1'b1;
      if (o.match_idx == MATCH_BITS'(NAME_LEN)) begin
        o.length_seen = 1'b1;
        o.phase       = PH_SKIP;
      end
    end else if (is_term(b)) begin
      o = start_run(st, b);
    end else begin
      o.phase = PH_LINE;
    end
    return o;
  endfunction

  function automatic state_t enter_body(input state_t st);
    state_t o;
    o           = st;
    o.remaining = st.declared;
    o.phase     = (st.declared != '0) ? PH_BODY : PH_NULLS;
    return o;
  endfunction

  function automatic state_t body_byte(input state_t st, input logic [7:0] b);
    state_t o;
    o = st;
    if (st.phase == PH_BODY) begin
      o.remaining = st.remaining - 1'b1;
      if (o.remaining == '0) begin
        o.phase = PH_NULLS;
      end
    end else if (st.phase == PH_NULLS) begin
      if (b == CHAR_NUL) begin
        o.nulls = sat_inc(st.nulls);
      end else begin
        o.phase = PH_DONE;
      end
    end
    return o;
  endfunction

  function automatic logic run_ends(input state_t st);
    return (st.term_count == 2'd3) || ((st.term_count == 2'd2) && st.pair_equal);
  endfunction

  // Per-byte state update
  always_comb begin
    logic                   second;
    logic [PROD_BITS-1:0]   prod;
    state_t                 t;
    s          = state_r;
    s.position = sat_inc(state_r.position);
    second     = (state_r.term_count == 2'd1) && !state_r.ws_seen;
    prod       = '0;
    t          = s;
    case (state_r.phase)
      PH_LINE: begin
        if (is_term(byte_in)) begin
          s = start_run(s, byte_in);
        end
      end
      PH_MATCH: begin
        s = match_byte(s, byte_in);
      end
      PH_SKIP: begin
        if ((byte_in == CHAR_COLON) || (byte_in == CHAR_SPACE)) begin
          s.phase = PH_SKIP;
        end else if (is_digit(byte_in)) begin
          s.declared = LENGTH_BITS'(byte_in - CHAR_ZERO);
          s.phase    = PH_DIGITS;
        end else begin
          s.bad_length = 1'b1;
          s.phase      = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(byte_in)) begin
          prod = (PROD_BITS'(state_r.declared) << 3) + (PROD_BITS'(state_r.declared) << 1)
               + PROD_BITS'(byte_in - CHAR_ZERO);
          s.declared = (prod > PROD_BITS'(LEN_MAX)) ? LEN_MAX : prod[LENGTH_BITS-1:0];
        end else if (is_term(byte_in)) begin
          s = start_run(s, byte_in);
        end else begin
          s.phase = PH_LINE;
        end
      end
      PH_RUN: begin
        if (is_term(byte_in)) begin
          if (second) begin
            s.pair_equal = ((byte_in == CHAR_LF) == state_r.first_lf);
          end
          if (state_r.term_count != 2'd3) begin
            s.term_count = state_r.term_count + 1'b1;
          end
        end else if ((state_r.term_count != 2'd3)
                     && ((byte_in == CHAR_SPACE) || (byte_in == CHAR_TAB))) begin
          if (second) begin
            s.pair_equal = 1'b0;
          end
          s.ws_seen = 1'b1;
        end else if (run_ends(state_r)) begin
          t            = s;
          t.header_end = s.position - 1'b1;
          t            = enter_body(t);
          s            = body_byte(t, byte_in);
        end else if (!state_r.length_seen) begin
          t           = s;
          t.phase     = PH_MATCH;
          t.match_idx = '0;
          s           = match_byte(t, byte_in);
        end else begin
          s.phase = PH_LINE;
        end
      end
      default: begin
        s = body_byte(s, byte_in);
      end
    endcase
  end

  // Close the message on its last byte
  always_comb begin
    logic [LENGTH_BITS:0] sum;
    fin = s;
    if (s.phase == PH_SKIP) begin
      fin.bad_length = 1'b1;
    end else if ((s.phase == PH_RUN) && run_ends(s)) begin
      fin.header_end = s.position;
      fin            = enter_body(fin);
    end
    sum = {1'b0, fin.declared} + {1'b0, fin.nulls};
    if (fin.bad_length) begin
      res.header_length = OUT_BITS'(fin.position);
      res.body_length   = '0;
      res.status        = ST_BAD_LENGTH;
    end else if ((fin.phase == PH_NULLS) || (fin.phase == PH_DONE)) begin
      res.header_length = OUT_BITS'(fin.header_end);
      res.body_length   = sum[LENGTH_BITS] ? OUT_BITS'(LEN_MAX)
                                           : OUT_BITS'(sum[LENGTH_BITS-1:0]);
      res.status        = ST_COMPLETE;
    end else if (fin.phase == PH_BODY) begin
      res.header_length = OUT_BITS'(fin.header_end);
      res.body_length   = OUT_BITS'(fin.declared);
      res.status        = ST_INCOMPLETE;
    end else begin
      res.header_length = OUT_BITS'(fin.position);
      res.body_length   = OUT_BITS'(fin.declared);
      res.status        = ST_INCOMPLETE;
    end
  end

  assign res_valid = fire && last_in;

  // Advance on each byte; clear after the last one
  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      state_nxt = last_in ? state_t'('0) : s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> rtl/core/text_message_length_finder.sv
// Top level of the text message length finder.
//
// Input channel: one message byte per item on in_tdata, with in_tlast on the
// final byte of the buffer. Result channel: one item per buffer, carrying the
// header length, body length and status (complete, incomplete, bad length).
// Only the item flagged by in_tlast produces a result; all other bytes only
// advance the header scanner.
// Throughput: one byte per cycle unless a final byte stalls, set by the
// combinational scanner update between input and state/result registers.
// Result path: the last byte sits in the input register until the scanner
// takes it; the result register is loaded as that byte is processed.
// Reset: synchronous, active low; clears all scanner state and both valid
// flags, so the next byte starts a new message. After each result the scanner
// also returns to its reset state on its own.
// Stall: while out_tready is low and a result waits, non-final bytes keep
// flowing; a final byte waits in the input register until the result
// register frees up, and in_tready stays low meanwhile.
module text_message_length_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [15:0] header_length, [31:16] body_length,
                                  // [33:32] status, [39:34] zero
);
  import tmlf_pkg::*;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_last;
  logic       fire;
  logic       res_valid;
  res_t       res;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  tmlf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (fire),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_last  (item_last)
  );

  // Process a byte unless it is final and the result register is still full
  assign fire = item_valid && (!item_last || !out_valid_r || out_tready);

  tmlf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (item_byte),
    .last_in   (item_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.status, res_r.body_length, res_r.header_length};
endmodule
